// ----- hdl/mqr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the mDNS query responder: sizes, header offsets and answer layout.
// No dependencies; the cfg interface, parser, emitter, top level and bench import it.
package mqr_pkg;

  localparam int unsigned MaxPacketBytesDefault = 512;
  localparam int unsigned NameLen   = 16;
  localparam int unsigned HeaderLen = 12;
  localparam int unsigned ReplyLen  = 42;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned PendW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLocalIpv4    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMatchNameHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMatchNameLow  = 2'd2;

  // Header byte offsets of interest.
  localparam int unsigned PosFlagsHigh  = 2;
  localparam int unsigned PosQdHigh     = 4;
  localparam int unsigned PosQdLow      = 5;
  localparam int unsigned PosFirstMatch = HeaderLen + NameLen - 1;

  // Answer field offsets and constant bytes.
  localparam logic [IdxW-1:0] AnsNameFirst = 6'd12;
  localparam logic [IdxW-1:0] AnsNameLast  = 6'd27;
  localparam logic [IdxW-1:0] AnsIpFirst   = 6'd38;
  localparam logic [IdxW-1:0] AnsFlagsHigh = 6'd2;
  localparam logic [IdxW-1:0] AnsCountLow  = 6'd7;
  localparam logic [IdxW-1:0] AnsTypeLow   = 6'd29;
  localparam logic [IdxW-1:0] AnsClassHigh = 6'd30;
  localparam logic [IdxW-1:0] AnsClassLow  = 6'd31;
  localparam logic [IdxW-1:0] AnsTtlLow    = 6'd35;
  localparam logic [IdxW-1:0] AnsLenLow    = 6'd37;
  localparam logic [IdxW-1:0] AnsLastIdx   = 6'(ReplyLen - 1);

  localparam logic [7:0] FlagsAuthHigh = 8'h84;
  localparam logic [7:0] ClassFlush    = 8'h80;
  localparam logic [7:0] TtlSeconds    = 8'h78;
  localparam logic [7:0] RdLength      = 8'h04;
  localparam logic [7:0] OneLow        = 8'h01;

  // One byte of the answer datagram at position idx.
  function automatic logic [7:0] reply_at(input logic [IdxW-1:0] idx,
                                          input logic [31:0] ipv4,
                                          input logic [127:0] name);
    logic [3:0] nsel;
    logic [1:0] isel;
    logic [7:0] res;
    nsel = 4'(idx - AnsNameFirst);
    isel = 2'(idx - AnsIpFirst);
    res  = 8'h00;
    priority if (idx >= AnsNameFirst && idx <= AnsNameLast) begin
      res = name[8'(127 - 8 * int'(nsel)) -: 8];
    end else if (idx >= AnsIpFirst && idx <= AnsLastIdx) begin
      res = ipv4[6'(31 - 8 * int'(isel)) -: 8];
    end else if (idx == AnsFlagsHigh) begin
      res = FlagsAuthHigh;
    end else if (idx == AnsCountLow || idx == AnsTypeLow || idx == AnsClassLow) begin
      res = OneLow;
    end else if (idx == AnsClassHigh) begin
      res = ClassFlush;
    end else if (idx == AnsTtlLow) begin
      res = TtlSeconds;
    end else if (idx == AnsLenLow) begin
      res = RdLength;
    end else begin
      res = 8'h00;
    end
    return res;
  endfunction

endpackage

// ----- hdl/mqr_rx_if.sv -----
`timescale 1ns / 1ps
// Received datagram byte channel.
// No dependencies.
interface mqr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ----- hdl/mqr_tx_if.sv -----
`timescale 1ns / 1ps
// Answer datagram byte channel.
// No dependencies.
interface mqr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;
  modport source (output valid, reply_byte, reply_last, input ready);
  modport sink   (input valid, reply_byte, reply_last, output ready);
endinterface

// ----- hdl/mqr_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on mqr_pkg for widths.
interface mqr_cfg_if
  import mqr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- hdl/mdns_query_responder.sv -----
`timescale 1ns / 1ps
// Top level of the mDNS A-record query responder.
// Depends on mqr_pkg, the channel interfaces, mqr_parser and mqr_emitter.
//
//   channel | dir | payload                  | role
//   --------+-----+--------------------------+-------------------------------------
//   rx      | in  | data_byte, last_byte     | received datagram, one byte a transfer
//   tx      | out | reply_byte, reply_last   | 42-byte answer, one byte a transfer
//   cfg     | in  | reg_index, wr_data       | register writes (ipv4, name high, low)
//
// One received byte is taken every cycle unless the queue is full; the parser updates
// its state in the same cycle the byte transfers. A qualifying last byte queues one
// answer; the emitter sends it one byte a cycle from its output register while tx is
// ready. Up to three answers may be queued; rx.ready drops only while the queue is
// full (a slow tx side). rst is synchronous and clears all datagram and queue state
// and the config registers. cfg is always ready; indexes past the list are dropped.
module mdns_query_responder
  import mqr_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic     clk,
  input  logic     rst,
  mqr_rx_if.sink   rx,
  mqr_tx_if.source tx,
  mqr_cfg_if.sink  cfg
);

  logic [31:0]  local_ipv4;
  logic [63:0]  match_name_high;
  logic [63:0]  match_name_low;
  logic         rx_accept;
  logic         trigger;
  logic         queue_full;

  // Configuration registers: take a write whenever it transfers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ipv4      <= '0;
      match_name_high <= '0;
      match_name_low  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        RegLocalIpv4:     local_ipv4      <= cfg.wr_data[31:0];
        RegMatchNameHigh: match_name_high <= cfg.wr_data;
        RegMatchNameLow:  match_name_low  <= cfg.wr_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Hold off input only when another answer could not be queued.
  assign rx.ready  = !queue_full;
  assign rx_accept = rx.valid && rx.ready;

  mqr_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (rx_accept),
    .data_byte (rx.data_byte),
    .last_byte (rx.last_byte),
    .name      ({match_name_high, match_name_low}),
    .trigger   (trigger)
  );

  mqr_emitter u_emitter (
    .clk     (clk),
    .rst     (rst),
    .trigger (trigger),
    .ipv4    (local_ipv4),
    .name    ({match_name_high, match_name_low}),
    .full    (queue_full),
    .tx      (tx)
  );

endmodule

// ----- hdl/mqr_parser.sv -----
`timescale 1ns / 1ps
// Datagram parser: byte count, header bits, sliding name window and answer decision.
// Depends on mqr_pkg.
module mqr_parser
  import mqr_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  input  logic [127:0] name,
  output logic         trigger
);

  localparam int unsigned CountW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CountW-1:0] MaxCount   = CountW'(MAX_PACKET_BYTES);
  localparam logic [CountW-1:0] CntFlags   = CountW'(PosFlagsHigh);
  localparam logic [CountW-1:0] CntQdHigh  = CountW'(PosQdHigh);
  localparam logic [CountW-1:0] CntQdLow   = CountW'(PosQdLow);
  localparam logic [CountW-1:0] CntMatch   = CountW'(PosFirstMatch);
  localparam logic [CountW-1:0] CntHeader  = CountW'(HeaderLen);

  logic [CountW-1:0]    byte_count, byte_count_next;
  logic [8*NameLen-1:0] name_window, name_window_next;
  logic                 response_bit, response_bit_next;
  logic                 question_nonzero, question_nonzero_next;
  logic                 name_found, name_found_next;
  logic                 in_range;

  always_comb begin
    in_range              = byte_count < MaxCount;
    byte_count_next       = byte_count;
    name_window_next      = name_window;
    response_bit_next     = response_bit;
    question_nonzero_next = question_nonzero;
    name_found_next       = name_found;
    if (in_range) begin
      if (byte_count == CntFlags) response_bit_next = data_byte[7];
      if (byte_count == CntQdHigh) question_nonzero_next = (data_byte != 8'h00);
      if (byte_count == CntQdLow && data_byte != 8'h00) question_nonzero_next = 1'b1;
      // oldest byte sits at the top, lined up with name byte 0
      name_window_next = {name_window[8*NameLen-9:0], data_byte};
      if (byte_count >= CntMatch && name_window_next == name) name_found_next = 1'b1;
      byte_count_next = byte_count + 1'b1;
    end
    trigger = accept && last_byte && byte_count_next >= CntHeader &&
              !response_bit_next && question_nonzero_next && name_found_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_count       <= '0;
      name_window      <= '0;
      response_bit     <= 1'b0;
      question_nonzero <= 1'b0;
      name_found       <= 1'b0;
    end else if (accept) begin
      byte_count       <= byte_count_next;
      name_window      <= name_window_next;
      response_bit     <= response_bit_next;
      question_nonzero <= question_nonzero_next;
      name_found       <= name_found_next;
    end
  end

endmodule

// ----- hdl/mqr_emitter.sv -----
`timescale 1ns / 1ps
// Answer generator: pending answer count, byte index and output register.
// Depends on mqr_pkg and mqr_tx_if.
module mqr_emitter
  import mqr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         trigger,
  input  logic [31:0]  ipv4,
  input  logic [127:0] name,
  output logic         full,
  mqr_tx_if.source     tx
);

  logic [PendW-1:0] pending, pending_next;
  logic [IdxW-1:0]  emit_index;
  logic             load, done;

  assign full = (pending == {PendW{1'b1}});
  assign load = (pending != '0) && (!tx.valid || tx.ready);
  assign done = load && (emit_index == AnsLastIdx);

  always_comb begin
    pending_next = pending;
    if (trigger && !done) pending_next = pending + 1'b1;
    else if (!trigger && done) pending_next = pending - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      emit_index <= '0;
      tx.valid   <= 1'b0;
    end else begin
      pending <= pending_next;
      if (load) begin
        tx.valid   <= 1'b1;
        emit_index <= done ? '0 : emit_index + 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx.reply_byte <= reply_at(emit_index, ipv4, name);
      tx.reply_last <= done;
    end
  end

endmodule

// ----- dv/mdns_query_responder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the mDNS A-record query responder: datagram bytes in,
// 42-byte answers out, checked against a behavioral model kept in this file.
// Depends on mqr_pkg, the rx/tx/cfg channel interfaces and mdns_query_responder.
module mdns_query_responder_tb;
  import mqr_pkg::*;

  // Block geometry and header offsets, as the protocol defines them.
  localparam int MaxPacket  = MaxPacketBytesDefault;
  localparam int HdrLen     = 12;
  localparam int NameBytes  = 16;
  localparam int AnswerLen  = 42;
  localparam int FlagsPos   = 2;
  localparam int QdHighPos  = 4;
  localparam int QdLowPos   = 5;
  localparam int FirstMatch = HdrLen + NameBytes - 1;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int StallLimit = 500;
  // Cycles to let the block settle once nothing is owed any more.
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 50;

  // Write to an index past the register list; the block must drop it.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // Host name "sensor01.local" in DNS label encoding, exactly 16 bytes.
  localparam logic [63:0] HostNameHigh = 64'h0873_656E_736F_7230;
  localparam logic [63:0] HostNameLow  = 64'h3105_6C6F_6361_6C00;
  // 192.168.1.77, with junk above bit 31 that the block must ignore.
  localparam logic [63:0] HostIpWord   = 64'hA5A5_5A5A_C0A8_014D;

  typedef enum logic [2:0] {CfgKeep, CfgZero, CfgOnes, CfgHost, CfgRandom} cfg_pick_e;
  // Where a datagram's verdict comes from: the model, or typed into the table.
  typedef enum logic [1:0] {VerdictModel, VerdictNone, VerdictAnswer} verdict_e;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } reply_t;

  // One directed datagram. name_at < 0 means no name is planted; corrupt >= 0
  // flips one bit of that name byte.
  typedef struct packed {
    cfg_pick_e  cfg;
    int         len;
    int         name_at;
    logic       resp;
    logic [7:0] qd_hi;
    logic [7:0] qd_lo;
    int         corrupt;
    verdict_e   verdict;
  } dir_row_t;

  localparam int DirCount = 5;
  localparam dir_row_t DirRows [DirCount] = '{
    // reset values: all-zero name and address, so a zero run after the header hits
    '{CfgKeep,  28,  12, 1'b0, 8'h00, 8'h01, -1, VerdictAnswer},
    // short datagrams: a lone byte, and one byte short of a header
    '{CfgKeep,   1,  -1, 1'b0, 8'h00, 8'h00, -1, VerdictNone},
    '{CfgKeep,  11,  -1, 1'b0, 8'h00, 8'h01, -1, VerdictNone},
    // all-ones registers
    '{CfgOnes,  28,  12, 1'b0, 8'h00, 8'h01, -1, VerdictAnswer},
    // name starting inside the header does not count
    '{CfgKeep,  27,  11, 1'b0, 8'h00, 8'h01, -1, VerdictNone}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mqr_rx_if  rx_ch ();
  mqr_tx_if  tx_ch ();
  mqr_cfg_if cfg_ch ();

  mdns_query_responder #(
    .MAX_PACKET_BYTES(MaxPacket)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .tx (tx_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies, updated as each write transfers.
  logic [31:0]  cur_ipv4 = '0;
  logic [127:0] cur_name = '0;

  // Per-datagram parse state of the model.
  int           pkt_len      = 0;
  logic [127:0] recent_bytes = '0;
  logic         resp_seen    = 1'b0;
  logic         qd_seen      = 1'b0;
  logic         name_seen    = 1'b0;

  reply_t       pending_answer[$];
  verdict_e     verdict_mode   = VerdictModel;
  int unsigned  answers_queued = 0;
  int unsigned  err_count      = 0;
  int unsigned  idle_cycles    = 0;
  logic [7:0]   dgram[$];
  reply_t       got_want;
  logic         tx_quiet = 1'b0;

  // Byte idx of the answer datagram for the given registers.
  function automatic logic [7:0] answer_byte(input int idx, input logic [31:0] ip,
                                             input logic [127:0] name);
    logic [7:0] v;
    v = 8'h00;
    if (idx >= 12 && idx < 28) begin
      v = name[127 - 8 * (idx - 12) -: 8];
    end else if (idx >= 38 && idx < AnswerLen) begin
      v = ip[31 - 8 * (idx - 38) -: 8];
    end else begin
      case (idx)
        2:           v = 8'h84;  // QR + AA
        7, 29, 31:   v = 8'h01;  // one answer, type A, class IN low
        30:          v = 8'h80;  // cache-flush bit
        35:          v = 8'h78;  // TTL 120 s
        37:          v = 8'h04;  // rdlength
        default:     v = 8'h00;
      endcase
    end
    return v;
  endfunction

  function automatic void enqueue_answer();
    reply_t r;
    for (int i = 0; i < AnswerLen; i++) begin
      r.value   = answer_byte(i, cur_ipv4, cur_name);
      r.is_last = (i == AnswerLen - 1);
      pending_answer.push_back(r);
    end
    answers_queued++;
  endfunction

  // Advance the model by one received byte; on the last mark decide the verdict
  // and clear the datagram state.
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    logic qualifies;
    if (pkt_len < MaxPacket) begin
      if (pkt_len == FlagsPos) resp_seen = b[7];
      if (pkt_len == QdHighPos) qd_seen = (b != 8'h00);
      if (pkt_len == QdLowPos && b != 8'h00) qd_seen = 1'b1;
      recent_bytes = {recent_bytes[119:0], b};
      if (pkt_len >= FirstMatch && recent_bytes == cur_name) name_seen = 1'b1;
      pkt_len++;
    end
    if (last) begin
      qualifies = (pkt_len >= HdrLen) && !resp_seen && qd_seen && name_seen;
      if (verdict_mode == VerdictAnswer || (verdict_mode == VerdictModel && qualifies))
        enqueue_answer();
      pkt_len      = 0;
      recent_bytes = '0;
      resp_seen    = 1'b0;
      qd_seen      = 1'b0;
      name_seen    = 1'b0;
    end
  endfunction

  // Feed the model on every received byte transfer.
  always @(posedge clk) begin
    if (!rst && rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1)
      absorb_byte(rx_ch.data_byte, rx_ch.last_byte);
  end

  // Compare every answer byte with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1) begin
      if (pending_answer.size() == 0) begin
        $error("reply byte %02h arrived with no answer owed", tx_ch.reply_byte);
        err_count++;
      end else begin
        got_want = pending_answer.pop_front();
        if (tx_ch.reply_byte !== got_want.value) begin
          $error("reply_byte: expected %02h, got %02h", got_want.value, tx_ch.reply_byte);
          err_count++;
        end
        if (tx_ch.reply_last !== got_want.is_last) begin
          $error("reply_last: expected %0b, got %0b", got_want.is_last, tx_ch.reply_last);
          err_count++;
        end
      end
    end
  end

  // Hang detector: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
        (tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Answer sink: a randomly drawn stall before each byte, with quiet stretches
  // where it takes every byte at once.
  initial begin
    int unsigned hold;
    tx_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
      hold = tx_quiet ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        tx_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      tx_ch.ready <= 1'b1;
      do @(posedge clk); while (!(tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1));
      @(negedge clk);
    end
  end

  // Present one byte and hold it until it transfers. Valid is left high so a
  // following byte with no gap goes out back to back.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic quiet);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.data_byte <= b;
    rx_ch.last_byte <= last;
    do @(posedge clk); while (!(rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1));
    @(negedge clk);
  endtask

  task automatic send_dgram(input verdict_e verdict);
    logic quiet;
    quiet = ($urandom_range(0, 3) == 0);
    verdict_mode = verdict;
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1, quiet);
  endtask

  // Random bytes with the header fields and the name planted where asked.
  function automatic void make_dgram(input int len, input int name_at, input logic resp,
                                     input logic [7:0] qd_hi, input logic [7:0] qd_lo,
                                     input int corrupt);
    logic [7:0] b;
    dgram.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == FlagsPos) b[7] = resp;
      if (i == QdHighPos) b = qd_hi;
      if (i == QdLowPos) b = qd_lo;
      if (name_at >= 0 && i >= name_at && i < name_at + NameBytes) begin
        b = cur_name[127 - 8 * (i - name_at) -: 8];
        if (i - name_at == corrupt) b = b ^ (8'h01 << $urandom_range(0, 7));
      end
      dgram.push_back(b);
    end
  endfunction

  // Drop valid and hold off until every owed answer byte is back.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (pending_answer.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // One register write; cfg valid is left high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= val;
    do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
    case (idx)
      RegLocalIpv4:     cur_ipv4 = val[31:0];
      RegMatchNameHigh: cur_name[127:64] = val;
      RegMatchNameLow:  cur_name[63:0] = val;
      default: ;  // past the list: dropped
    endcase
    @(negedge clk);
  endtask

  // Write all three registers in a rotated order, sometimes followed by a stray write
  // to the unused index.
  task automatic program_regs(input logic [63:0] ip_word, input logic [63:0] hi,
                              input logic [63:0] lo);
    logic [CfgIdxW-1:0] order [3];
    logic [63:0]        vals [3];
    int unsigned        first;
    order = '{RegLocalIpv4, RegMatchNameHigh, RegMatchNameLow};
    vals  = '{ip_word, hi, lo};
    first = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) write_reg(order[(first + k) % 3], vals[(first + k) % 3]);
    if ($urandom_range(0, 1) == 1) write_reg(RegUnused, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_cfg(input cfg_pick_e pick);
    case (pick)
      CfgZero:   program_regs('0, '0, '0);
      CfgOnes:   program_regs('1, '1, '1);
      CfgHost:   program_regs(HostIpWord, HostNameHigh, HostNameLow);
      CfgRandom: program_regs({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom});
      default: ;
    endcase
  endtask

  initial begin
    int          len;
    int          name_at;
    int          corrupt;
    int          roll;
    logic        resp;
    logic [7:0]  qd_hi;
    logic [7:0]  qd_lo;
    int unsigned rand_bytes;
    int unsigned answers_mark;
    int unsigned dgram_num;
    cfg_pick_e   pick;

    rx_ch.valid      = 1'b0;
    rx_ch.data_byte  = 8'h00;
    rx_ch.last_byte  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = RegLocalIpv4;
    cfg_ch.wr_data   = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed datagrams; registers change only once all answers are back.
    for (int r = 0; r < DirCount; r++) begin
      if (DirRows[r].cfg != CfgKeep) begin
        settle();
        apply_cfg(DirRows[r].cfg);
      end
      make_dgram(DirRows[r].len, DirRows[r].name_at, DirRows[r].resp,
                 DirRows[r].qd_hi, DirRows[r].qd_lo, DirRows[r].corrupt);
      send_dgram(DirRows[r].verdict);
    end

    // Random datagrams: mostly well-formed queries carrying the current name,
    // the rest noise, short packets and queries broken in one way.
    rand_bytes   = 0;
    dgram_num    = 0;
    answers_mark = answers_queued;
    while (rand_bytes < 60 || answers_queued - answers_mark < 2) begin
      if (dgram_num % 4 == 0) begin
        settle();
        pick = ($urandom_range(0, 1) == 1) ? CfgRandom : cfg_pick_e'($urandom_range(1, 3));
        apply_cfg(pick);
      end else if ($urandom_range(0, 9) == 0) begin
        settle();
      end

      name_at = HdrLen + $urandom_range(0, 4);
      len     = name_at + NameBytes + $urandom_range(0, 6);
      resp    = 1'b0;
      qd_hi   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
      qd_lo   = 8'($urandom_range(1, 255));
      corrupt = -1;
      roll    = $urandom_range(0, 9);
      if (roll == 7) begin
        // noise
        len     = $urandom_range(1, 40);
        name_at = -1;
        resp    = 1'($urandom);
        qd_hi   = 8'($urandom);
        qd_lo   = 8'($urandom);
      end else if (roll == 8) begin
        // a query broken in exactly one way
        case ($urandom_range(0, 3))
          0:       resp = 1'b1;
          1:       begin qd_hi = 8'h00; qd_lo = 8'h00; end
          2:       corrupt = $urandom_range(0, NameBytes - 1);
          default: begin name_at = HdrLen - 1; len = name_at + NameBytes; end
        endcase
      end else if (roll == 9) begin
        len     = $urandom_range(1, HdrLen);
        name_at = -1;
      end
      make_dgram(len, name_at, resp, qd_hi, qd_lo, corrupt);
      send_dgram(VerdictModel);
      rand_bytes += dgram.size();
      dgram_num++;
    end

    settle();
    repeat (TailCycles) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mqr_pkg.sv
hdl/mqr_rx_if.sv
hdl/mqr_tx_if.sv
hdl/mqr_cfg_if.sv
hdl/mqr_parser.sv
hdl/mqr_emitter.sv
hdl/mdns_query_responder.sv
dv/mdns_query_responder_tb.sv
